// ===== rtl/fnmf_pkg.sv =====
`timescale 1ns / 1ps

package fnmf_pkg;

   localparam int COL_BITS = 11;
   localparam int ROW_BITS = 12;
   localparam int WIDTH_BITS = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam int OUT_BITS = 8;
   localparam int MEAN_SHIFT = 2;
   localparam int MIN_SIZE = 3;
   localparam int ROW_LIMIT = 4096;
   localparam int COL_CAP = 2048;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd1080;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1920;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic hit;
      logic frame_end;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } tag_type;

endpackage

// ===== rtl/four_neighbour_mean_filter_top.sv =====
`timescale 1ns / 1ps
// Four-neighbour mean filter for an RGB pixel stream in raster order.
// Request channel (req_*): one pixel per accepted request, row 0 first,
// column 0 first within a row. Response channel (rsp_*): one smoothed
// interior pixel with its row and column; rsp_frame_end marks the last
// interior pixel of the frame. Border pixels give no response.
// Each channel of a response is (up + down + left + right) >> 2.
// The response of an interior pixel is formed from the request of the pixel
// just below it, which passes the s1 register into the output register.
// Throughput: one pixel per cycle while no stalled response holds the
// pipeline, sustained by a line memory holding the two previous rows with
// two read ports and one write port; a pixel reads its own column and the
// next one at acceptance and writes back as it leaves the s1 register.
// Stall: when rsp_stall holds a pending response, the next request is
// taken only if the s1 register is empty or holds a pixel that gives no response.
// Reset clears the row and column counters and loads the default frame
// size (1080 by 1920); line memory contents are not cleared.
// csr_index selects frame_width or frame_height; write only while idle.

module four_neighbour_mean_filter_top #(
   parameter int MAX_LINE_WIDTH = 2048,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_red_in,
   input  logic [7:0]                           req_green_in,
   input  logic [7:0]                           req_blue_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fnmf_pkg::OUT_BITS-1:0]        rsp_red_out,
   output logic [fnmf_pkg::OUT_BITS-1:0]        rsp_green_out,
   output logic [fnmf_pkg::OUT_BITS-1:0]        rsp_blue_out,
   output logic [fnmf_pkg::ROW_BITS-1:0]        rsp_out_row,
   output logic [fnmf_pkg::COL_BITS-1:0]        rsp_out_col,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write_en,
   input  logic [fnmf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fnmf_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int DEPTH = (MAX_LINE_WIDTH < fnmf_pkg::COL_CAP) ?
                          MAX_LINE_WIDTH : fnmf_pkg::COL_CAP;
   localparam int AW = $clog2(DEPTH);
   localparam int CB = CHANNEL_BITS;
   localparam int PIX_W = 3 * CB;
   localparam int SUM_W = CB + 2;
   localparam int WB = fnmf_pkg::WIDTH_BITS;
   localparam int HB = fnmf_pkg::HEIGHT_BITS;
   localparam int CLB = fnmf_pkg::COL_BITS;
   localparam int RWB = fnmf_pkg::ROW_BITS;

   logic [WB-1:0]  fw_ff, fw_in;
   logic [HB-1:0]  fh_ff, fh_in;
   logic [CLB-1:0] col_ff, col_in;
   logic [RWB-1:0] row_ff, row_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_pix_ff;
   fnmf_pkg::tag_type   s1_tag_ff, tag_in;
   logic [PIX_W-1:0]    left_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fnmf_pkg::OUT_BITS-1:0] red_ff, green_ff, blue_ff;
   logic [fnmf_pkg::OUT_BITS-1:0] mean_ch [3];
   logic [RWB-1:0]                orow_ff;
   logic [CLB-1:0]                ocol_ff;
   logic                          oend_ff;

   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic          accept;
   logic          out_free;
   logic          s1_adv;
   logic [PIX_W-1:0] pix_in;

   logic [AW-1:0]      rd_addr_a, rd_addr_b;
   logic [CLB:0]       col_plus;
   logic [2*PIX_W-1:0] rd_a, rd_b;
   logic [PIX_W-1:0]   up_px, right_px, newer_c;

   // frame size clamp
   always_comb begin
      if (fw_ff < WB'(fnmf_pkg::MIN_SIZE)) begin
         w_eff = WB'(fnmf_pkg::MIN_SIZE);
      end else if (fw_ff > WB'(DEPTH)) begin
         w_eff = WB'(DEPTH);
      end else begin
         w_eff = fw_ff;
      end
      if (fh_ff < HB'(fnmf_pkg::MIN_SIZE)) begin
         h_eff = HB'(fnmf_pkg::MIN_SIZE);
      end else if (fh_ff > HB'(fnmf_pkg::ROW_LIMIT)) begin
         h_eff = HB'(fnmf_pkg::ROW_LIMIT);
      end else begin
         h_eff = fh_ff;
      end
   end

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            fnmf_pkg::CSR_FRAME_WIDTH:  fw_in = csr_data[WB-1:0];
            fnmf_pkg::CSR_FRAME_HEIGHT: fh_in = csr_data;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_tag_ff.hit || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign pix_in = {CB'(req_blue_in), CB'(req_green_in), CB'(req_red_in)};

   // position decode and counter advance
   always_comb begin
      tag_in.hit = ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff) &&
                   (row_ff >= RWB'(2)) && (col_ff >= CLB'(1)) &&
                   ({1'b0, col_ff} <= (w_eff - WB'(2)));
      tag_in.frame_end = ({1'b0, row_ff} == (h_eff - HB'(1))) &&
                         ({1'b0, col_ff} == (w_eff - WB'(2)));
      tag_in.row = row_ff - RWB'(1);
      tag_in.col = col_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (({1'b0, col_ff} + WB'(1)) >= w_eff) begin
            col_in = '0;
            if (({1'b0, row_ff} + HB'(1)) >= h_eff) begin
               row_in = '0;
            end else begin
               row_in = row_ff + RWB'(1);
            end
         end else begin
            col_in = col_ff + CLB'(1);
         end
      end
   end

   assign col_plus  = {1'b0, col_ff} + (CLB+1)'(1);
   assign rd_addr_a = col_ff[AW-1:0];
   assign rd_addr_b = (col_plus >= (CLB+1)'(DEPTH)) ? '0 : col_plus[AW-1:0];

   fnmf_line_ram #(
      .DEPTH  (DEPTH),
      .DATA_W (2 * PIX_W),
      .AW     (AW)
   ) u_line_ram (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b),
      .wr_en     (s1_adv),
      .wr_addr   (s1_tag_ff.col[AW-1:0]),
      .wr_data   ({newer_c, s1_pix_ff})
   );

   // entry layout: {older, newer}
   assign up_px    = rd_a[2*PIX_W-1:PIX_W];
   assign newer_c  = rd_a[PIX_W-1:0];
   assign right_px = rd_b[PIX_W-1:0];

   for (genvar k = 0; k < 3; k++) begin : g_chan
      logic [SUM_W-1:0] sum;
      assign sum = SUM_W'(up_px[k*CB +: CB]) + SUM_W'(left_ff[k*CB +: CB]) +
                   SUM_W'(right_px[k*CB +: CB]) + SUM_W'(s1_pix_ff[k*CB +: CB]);
      assign mean_ch[k] = fnmf_pkg::OUT_BITS'(sum >> fnmf_pkg::MEAN_SHIFT);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_tag_ff.hit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= fnmf_pkg::WIDTH_RESET;
         fh_ff        <= fnmf_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= pix_in;
         s1_tag_ff <= tag_in;
      end
      if (s1_adv) begin
         left_ff <= newer_c;
      end
      if (s1_adv && s1_tag_ff.hit) begin
         red_ff   <= mean_ch[0];
         green_ff <= mean_ch[1];
         blue_ff  <= mean_ch[2];
         orow_ff  <= s1_tag_ff.row;
         ocol_ff  <= s1_tag_ff.col;
         oend_ff  <= s1_tag_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_out_row   = orow_ff;
   assign rsp_out_col   = ocol_ff;
   assign rsp_frame_end = oend_ff;

endmodule

// ===== rtl/fnmf_line_ram.sv =====
`timescale 1ns / 1ps

module fnmf_line_ram #(
   parameter int DEPTH = 2048,
   parameter int DATA_W = 48,
   parameter int AW = 11
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
